// ===== src/cbm_pkg.sv =====
// Shared types, command codes and a helper function for the coverage bitmap merge unit.
// Depends on nothing; imported by coverage_bitmap_merge_unit.
package cbm_pkg;

    localparam int WORD_W  = 32;
    localparam int WORD_AW = 5;

    localparam int CMD_W   = 3;
    localparam int THR_W   = 2;
    localparam int IDX_W   = 12;
    localparam int CNT_W   = 13;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 48;

    localparam logic [CMD_W-1:0] CMD_MARK       = 3'd0;
    localparam logic [CMD_W-1:0] CMD_COMMIT     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CLR_THREAD = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CHECK      = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLR_ALL    = 3'd4;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_MARK_RD,
        S_MARK_WR,
        S_WALK,
        S_CLR_T,
        S_CLR_G,
        S_DONE
    } state_t;

    function automatic logic [WORD_AW:0] popcount_word(input logic [WORD_W-1:0] w);
        logic [WORD_AW:0] sum;
        sum = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            sum = sum + {{WORD_AW{1'b0}}, w[i]};
        end
        return sum;
    endfunction

endpackage

// ===== src/coverage_bitmap_merge_unit.sv =====
// Coverage bitmap merge unit: global and per-thread coverage maps with a word-serial sequencer.
// Depends on cbm_pkg for command codes, the state type and the word popcount.

// The maps are stored as 32-bit words in two single-port-write memories, and one
// word is handled per cycle by a three-stage read, merge and count path. A mark that
// is taken passes through a read state and a write state that sets the bit (read,
// modify, write) before its result is loaded. A dropped mark, an unknown command, or
// a commit, check or thread clear for a thread beyond the thread count goes straight
// to the done state. A commit or check walks ceil(n / 32) memory words, where n is the
// size in use clipped to MAP_DEPTH (for a check, the check length clipped to it). A
// thread clear and a clear all each step through every word of their map. The input
// is ready again from the cycle after the result is loaded, and a finished transaction
// waits while an earlier result is still held on the output. After reset a clearing
// pass over both maps runs before the first transaction is taken; configuration
// writes are taken at any time.
module coverage_bitmap_merge_unit #(
    parameter int MAP_DEPTH    = 4096,
    parameter int THREAD_COUNT = 4
) (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [cbm_pkg::CNT_W-1:0]        cfg_data,    // size_in_use

    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [cbm_pkg::IN_DATA_W-1:0]    s_tdata,     // thread, index, check_length
    input  logic [cbm_pkg::CMD_W-1:0]        s_tuser,     // cmd

    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [cbm_pkg::OUT_DATA_W-1:0]   m_tdata      // new count, covered_count,
                                                          // total_bits, complete, ignored
);
    import cbm_pkg::*;

    localparam int WORDS  = (MAP_DEPTH + WORD_W - 1) / WORD_W;
    localparam int AW     = $clog2(WORDS);
    localparam int TDEPTH = THREAD_COUNT * WORDS;
    localparam int TAW    = $clog2(TDEPTH);
    localparam int CW     = $clog2(TDEPTH + 1);

    logic [WORD_W-1:0] tmem [TDEPTH];
    logic [WORD_W-1:0] gmem [WORDS];

    state_t state_reg, state_next;

    logic [CW-1:0]     cnt_reg;
    logic [CW-1:0]     end_reg;
    logic [CMD_W-1:0]  cmd_reg;
    logic [TAW-1:0]    base_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  lim_reg;
    logic [CNT_W-1:0]  size_reg;
    logic [CNT_W-1:0]  covered_reg;
    logic              complete_reg;
    logic [CNT_W-1:0]  newb_reg;
    logic              all_reg;
    logic              ign_reg;

    logic              p1_valid_reg;
    logic [AW-1:0]     p1_addr_reg;
    logic [WORD_W-1:0] p1_mask_reg;
    logic              p2_valid_reg;
    logic [WORD_W-1:0] p2_word_reg;

    logic [WORD_W-1:0] t_rdata_reg;
    logic [WORD_W-1:0] g_rdata_reg;

    logic              m_valid_reg;
    logic [CNT_W-1:0]  o_new_reg;
    logic [CNT_W-1:0]  o_cov_reg;
    logic [CNT_W-1:0]  o_total_reg;
    logic              o_complete_reg;
    logic              o_ignored_reg;

    logic [CMD_W-1:0]  in_cmd;
    logic [THR_W-1:0]  in_thr;
    logic [IDX_W-1:0]  in_idx;
    logic [CNT_W-1:0]  in_len;
    logic              in_thr_ok;
    logic              in_ignore;
    logic [CNT_W-1:0]  in_lim;
    logic [CW-1:0]     in_end;
    logic [TAW-1:0]    in_base;
    logic [CNT_W-1:0]  eff_size;
    logic              s_acc;

    logic              walk_issue;
    logic [CNT_W-1:0]  walk_rem;
    logic [WORD_W-1:0] walk_mask;
    logic [WORD_W-1:0] new_word;
    logic [CNT_W-1:0]  cov_upd;
    logic              cmp_upd;
    logic              out_load;

    logic              t_we;
    logic [TAW-1:0]    t_waddr;
    logic [TAW-1:0]    t_raddr;
    logic [WORD_W-1:0] t_wdata;
    logic              g_we;
    logic [AW-1:0]     g_waddr;
    logic [AW-1:0]     g_raddr;
    logic [WORD_W-1:0] g_wdata;

    assign in_cmd = s_tuser;
    assign in_thr = s_tdata[1:0];
    assign in_idx = s_tdata[13:2];
    assign in_len = s_tdata[26:14];

    assign eff_size  = (int'(size_reg) > MAP_DEPTH) ? CNT_W'(MAP_DEPTH) : size_reg;
    assign in_thr_ok = int'(in_thr) < THREAD_COUNT;
    assign in_ignore = !in_thr_ok || (CNT_W'(in_idx) >= eff_size);
    assign in_lim    = ((in_cmd == CMD_CHECK) && (in_len < eff_size)) ? in_len : eff_size;
    assign in_end    = CW'(({1'b0, in_lim} + 14'd31) >> WORD_AW);
    assign in_base   = TAW'(int'(in_thr) * WORDS);

    assign s_tready  = (state_reg == S_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign walk_issue = (state_reg == S_WALK) && (cnt_reg < end_reg);
    assign walk_rem   = lim_reg - CNT_W'({cnt_reg, {WORD_AW{1'b0}}});
    assign walk_mask  = (walk_rem >= CNT_W'(WORD_W)) ? {WORD_W{1'b1}}
                      : ((WORD_W'(1) << walk_rem[WORD_AW-1:0]) - WORD_W'(1));
    assign new_word   = t_rdata_reg & ~g_rdata_reg & p1_mask_reg;

    assign out_load = (state_reg == S_DONE) && (!m_valid_reg || m_tready);

    always_comb
    begin
        cov_upd = covered_reg;
        cmp_upd = complete_reg;
        case (cmd_reg)
            CMD_COMMIT:
            begin
                cov_upd = covered_reg + newb_reg;
                if ((newb_reg != '0) && all_reg)
                begin
                    cmp_upd = 1'b1;
                end
            end
            CMD_CLR_ALL:
            begin
                cov_upd = '0;
                cmp_upd = 1'b0;
            end
            default:
            begin
                cov_upd = covered_reg;
            end
        endcase
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT:
            begin
                if (cnt_reg == CW'(TDEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_acc)
                begin
                    case (in_cmd)
                        CMD_MARK:       state_next = in_ignore ? S_DONE : S_MARK_RD;
                        CMD_COMMIT:     state_next = in_thr_ok ? S_WALK : S_DONE;
                        CMD_CHECK:      state_next = in_thr_ok ? S_WALK : S_DONE;
                        CMD_CLR_THREAD: state_next = in_thr_ok ? S_CLR_T : S_DONE;
                        CMD_CLR_ALL:    state_next = S_CLR_G;
                        default:        state_next = S_DONE;
                    endcase
                end
            end
            S_MARK_RD:
            begin
                state_next = S_MARK_WR;
            end
            S_MARK_WR:
            begin
                state_next = S_DONE;
            end
            S_WALK:
            begin
                if (!walk_issue && !p1_valid_reg && !p2_valid_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_CLR_T, S_CLR_G:
            begin
                if (cnt_reg == CW'(WORDS - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    // Memory control outputs.
    always_comb
    begin
        t_we    = 1'b0;
        t_waddr = in_base;
        t_raddr = base_reg + TAW'(cnt_reg[AW-1:0]);
        t_wdata = '0;
        g_we    = 1'b0;
        g_waddr = p1_addr_reg;
        g_raddr = cnt_reg[AW-1:0];
        g_wdata = g_rdata_reg | (t_rdata_reg & p1_mask_reg);
        case (state_reg)
            S_INIT:
            begin
                t_we    = 1'b1;
                t_waddr = cnt_reg[TAW-1:0];
                g_we    = (cnt_reg < CW'(WORDS));
                g_waddr = cnt_reg[AW-1:0];
                g_wdata = '0;
            end
            S_MARK_RD:
            begin
                t_raddr = base_reg + TAW'(idx_reg >> WORD_AW);
            end
            S_MARK_WR:
            begin
                t_we    = 1'b1;
                t_waddr = base_reg + TAW'(idx_reg >> WORD_AW);
                t_wdata = t_rdata_reg | (WORD_W'(1) << idx_reg[WORD_AW-1:0]);
            end
            S_WALK:
            begin
                g_we = p1_valid_reg && (cmd_reg == CMD_COMMIT);
            end
            S_CLR_T:
            begin
                t_we    = 1'b1;
                t_waddr = base_reg + TAW'(cnt_reg[AW-1:0]);
            end
            S_CLR_G:
            begin
                g_we    = 1'b1;
                g_waddr = cnt_reg[AW-1:0];
                g_wdata = '0;
            end
            default:
            begin
                t_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (t_we)
        begin
            tmem[t_waddr] <= t_wdata;
        end
        t_rdata_reg <= tmem[t_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (g_we)
        begin
            gmem[g_waddr] <= g_wdata;
        end
        g_rdata_reg <= gmem[g_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INIT;
            cnt_reg      <= '0;
            size_reg     <= CNT_W'(4096);
            covered_reg  <= '0;
            complete_reg <= 1'b0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                size_reg <= cfg_data;
            end

            case (state_reg)
                S_INIT, S_CLR_T, S_CLR_G:
                begin
                    cnt_reg <= cnt_reg + CW'(1);
                end
                S_WALK:
                begin
                    if (walk_issue)
                    begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                end
                default:
                begin
                    cnt_reg <= '0;
                end
            endcase

            p1_valid_reg <= walk_issue;
            p2_valid_reg <= p1_valid_reg;

            if (out_load)
            begin
                covered_reg  <= cov_upd;
                complete_reg <= cmp_upd;
                m_valid_reg  <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            cmd_reg  <= in_cmd;
            base_reg <= in_base;
            idx_reg  <= in_idx;
            lim_reg  <= in_lim;
            end_reg  <= in_end;
            newb_reg <= '0;
            all_reg  <= 1'b1;
            ign_reg  <= (in_cmd == CMD_MARK) && in_ignore;
        end
        else
        begin
            if (p1_valid_reg)
            begin
                all_reg <= all_reg && (&(g_rdata_reg | t_rdata_reg | ~p1_mask_reg));
            end
            if (p2_valid_reg)
            begin
                newb_reg <= newb_reg + CNT_W'(popcount_word(p2_word_reg));
            end
        end

        p1_addr_reg <= cnt_reg[AW-1:0];
        p1_mask_reg <= walk_mask;
        p2_word_reg <= new_word;

        if (out_load)
        begin
            o_new_reg      <= newb_reg;
            o_cov_reg      <= cov_upd;
            o_total_reg    <= eff_size;
            o_complete_reg <= cmp_upd;
            o_ignored_reg  <= ign_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, o_ignored_reg, o_complete_reg, o_total_reg, o_cov_reg, o_new_reg};

`ifndef ASSERT_OFF
    a_init_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INIT) |-> !s_tready)
        else $error("input taken during the clearing pass");

    a_pipe_order: assert property (@(posedge clk) disable iff (!rst_n)
        p2_valid_reg |-> $past(p1_valid_reg))
        else $error("count stage active without a merge stage before it");

    a_mark_rmw: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MARK_WR) |-> $past(state_reg == S_MARK_RD))
        else $error("mark write without a preceding read");

    a_complete_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(complete_reg) |-> $past((state_reg == S_DONE) && (cmd_reg == CMD_CLR_ALL)))
        else $error("complete flag dropped without a clear all");

    a_ignored_no_new: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && o_ignored_reg) |-> (o_new_reg == '0))
        else $error("ignored mark reported new bits");
`endif

endmodule
